FILE: design/pidaw_pkg.sv
// pidaw_pkg: shared constants, types and sequencer states for the pid regulator
// no dependencies
package pidaw_pkg;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam logic [31:0] MIN_STEP_DEF = 32'd0;
  localparam int unsigned DISC_FRAC = 16;
  localparam int unsigned STEP_FRAC = 24;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_RESET  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_I   = 3'd1;
  localparam logic [2:0] REG_GAIN_D   = 3'd2;
  localparam logic [2:0] REG_OUT_MIN  = 3'd3;
  localparam logic [2:0] REG_OUT_MAX  = 3'd4;
  localparam logic [2:0] REG_BIAS     = 3'd5;
  localparam logic [2:0] REG_DISCOUNT = 3'd6;
  localparam logic [2:0] REG_MODE     = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_P, ST_DISC, ST_EI, ST_INC, ST_DIV, ST_D, ST_SUM, ST_FIN, ST_OUT
  } state_t;
endpackage

FILE: design/pid_controller_antiwindup.sv
// pid_controller_antiwindup: top level, sequenced pid regulator with one shared
// multiplier and a restoring divider; depends on pidaw_pkg
//
// usage: the in_ channel carries a command (update, reset, clear integral), goal,
// measured and step_time. each accepted item produces exactly one transfer on the
// out_ channel carrying drive and integral_now.
// processing per command: reset, clear and unused commands go straight to the
// output register; a disabled update (mode bit 0 clear) forms only the
// proportional product; an update with step_time at or below MIN_STEP forms the
// proportional product and sums it with bias and integral; a full update runs
// four products on the shared 32x32 multiplier (low and high half), the serial
// divider (one quotient bit per cycle over a 66 bit dividend, then the sign fix),
// the derivative product, the final sums and the output register. in_ready is
// high only while the sequencer is idle; the result stays in the output register
// until out_ready, and a new item is taken only after that transfer.
// cfg_ writes are always accepted and should only be issued while idle.
// rst_n (synchronous) loads the register reset values and clears the integral,
// last error and held output.
module pid_controller_antiwindup #(
  parameter int unsigned FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF,
  parameter logic [31:0] MIN_STEP  = pidaw_pkg::MIN_STEP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_goal,
  input  logic signed [31:0] in_measured,
  input  logic [31:0]        in_step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_drive,
  output logic signed [31:0] out_integral_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam logic signed [63:0] LIM = 64'sh4000_0000_0000_0000;
  localparam int unsigned DW = 66;

  pidaw_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r, out_min_r, out_max_r, bias_r;
  logic [17:0] discount_r;
  logic [1:0]  mode_r;

  // regulator state
  logic signed [31:0] integ_r, held_r;
  logic signed [32:0] prev_r;

  // item and scratch
  logic signed [32:0] err_r;
  logic [31:0] step_r;
  logic signed [63:0] p_r, disc_r, ei_r, inc_r, q_r, d_r, icl_r, pb_r;
  logic [DW-1:0] rem_r, dvd_r;
  logic dneg_r;
  logic [6:0] cnt_r;

  // multiplier pass: low half product kept from the first pass for the second
  logic mph_r;
  logic [63:0] plo_r;
  logic mul_st;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == pidaw_pkg::ST_IDLE);
  assign out_valid = (state_r == pidaw_pkg::ST_OUT);
  assign out_drive = held_r;
  assign out_integral_now = integ_r;
  assign mul_st = state_r inside {pidaw_pkg::ST_P, pidaw_pkg::ST_DISC, pidaw_pkg::ST_EI,
                                  pidaw_pkg::ST_INC, pidaw_pkg::ST_D};

  // shared multiplier operands
  logic signed [63:0] ma;
  logic signed [32:0] mb;
  logic [6:0] msh;
  always_comb begin
    ma = 64'(err_r);
    mb = 33'(gain_p_r);
    msh = 7'(FRAC_BITS);
    case (state_r)
      pidaw_pkg::ST_DISC: begin
        ma = 64'(integ_r); mb = $signed({15'd0, discount_r}); msh = 7'(pidaw_pkg::DISC_FRAC);
      end
      pidaw_pkg::ST_EI: begin
        ma = 64'(err_r); mb = 33'(gain_i_r);
      end
      pidaw_pkg::ST_INC: begin
        ma = ei_r; mb = $signed({1'b0, step_r}); msh = 7'(pidaw_pkg::STEP_FRAC);
      end
      pidaw_pkg::ST_D: begin
        ma = q_r; mb = 33'(gain_d_r);
      end
      default: ;
    endcase
  end

  // magnitude multiply in two 32x32 passes, shift toward zero, saturate to 2^62
  logic [63:0] mag_a;
  logic [31:0] mag_b;
  logic [63:0] prod_lo, prod_hi;
  logic [96:0] prod;
  logic [96:0] psh;
  logic [63:0] mres;
  logic mneg;
  always_comb begin
    mag_a = ma[63] ? 64'(-ma) : 64'(ma);
    mag_b = mb[32] ? 32'(-mb) : 32'(mb);
    mneg  = ma[63] ^ mb[32];
    prod_lo = 64'(mag_a[31:0]) * 64'(mag_b);
    prod_hi = 64'(mag_a[63:32]) * 64'(mag_b);
    prod  = {1'b0, prod_hi, 32'd0} + {33'd0, plo_r};
    psh   = prod >> msh;
    if (psh > 97'(LIM)) mres = 64'(LIM);
    else mres = psh[63:0];
    if (mneg) mres = -mres;
  end

  // pass sequencing for the shared multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) mph_r <= 1'b0;
    else if (mul_st) mph_r <= !mph_r;
    else mph_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (mul_st && !mph_r) plo_r <= prod_lo;
  end

  // divider trial subtraction
  logic [DW:0] trial;
  always_comb trial = {rem_r, dvd_r[DW-1]} - {35'd0, step_r};

  // final sums
  logic signed [63:0] d_sat, integ_sum, integ_cl, unc, out_cl, disc_sat;
  logic signed [63:0] lo64, hi64;
  logic dir_pos, dir_neg, hold_int;
  always_comb begin
    lo64 = 64'(out_min_r);
    hi64 = 64'(out_max_r);
    d_sat = d_r;
    if (d_sat < -64'sd2147483648) d_sat = -64'sd2147483648;
    if (d_sat > 64'sd2147483647) d_sat = 64'sd2147483647;
    disc_sat = disc_r;
    if (disc_sat < -64'sd2147483648) disc_sat = -64'sd2147483648;
    if (disc_sat > 64'sd2147483647) disc_sat = 64'sd2147483647;
    integ_sum = disc_r + inc_r;
    integ_cl = integ_sum;
    if (integ_cl < lo64) integ_cl = lo64;
    if (integ_cl > hi64) integ_cl = hi64;
    unc = pb_r + icl_r + d_sat;
    dir_pos = (err_r != 0) && (gain_i_r != 0) && (err_r[32] == gain_i_r[31]);
    dir_neg = (err_r != 0) && (gain_i_r != 0) && (err_r[32] != gain_i_r[31]);
    hold_int = mode_r[1] && ((unc > hi64 && dir_pos) || (unc < lo64 && dir_neg));
    out_cl = pb_r + (hold_int ? disc_sat : icl_r) + d_sat;
    if (out_cl < lo64) out_cl = lo64;
    if (out_cl > hi64) out_cl = hi64;
  end

  logic signed [63:0] pfin;
  always_comb begin
    pfin = 64'(bias_r) + p_r + 64'(integ_r);
    if (pfin < lo64) pfin = lo64;
    if (pfin > hi64) pfin = hi64;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pidaw_pkg::ST_IDLE: if (in_valid) begin
        if (in_cmd == pidaw_pkg::CMD_UPDATE) state_nxt = pidaw_pkg::ST_P;
        else state_nxt = pidaw_pkg::ST_OUT;
      end
      pidaw_pkg::ST_P: if (mph_r) begin
        if (!mode_r[0]) state_nxt = pidaw_pkg::ST_OUT;
        else if (step_r > MIN_STEP) state_nxt = pidaw_pkg::ST_DISC;
        else state_nxt = pidaw_pkg::ST_FIN;
      end
      pidaw_pkg::ST_DISC: if (mph_r) state_nxt = pidaw_pkg::ST_EI;
      pidaw_pkg::ST_EI:   if (mph_r) state_nxt = pidaw_pkg::ST_INC;
      pidaw_pkg::ST_INC:  if (mph_r) state_nxt = pidaw_pkg::ST_DIV;
      pidaw_pkg::ST_DIV:  if (cnt_r == 7'(DW)) state_nxt = pidaw_pkg::ST_D;
      pidaw_pkg::ST_D:    if (mph_r) state_nxt = pidaw_pkg::ST_SUM;
      pidaw_pkg::ST_SUM:  state_nxt = pidaw_pkg::ST_OUT;
      pidaw_pkg::ST_FIN:  state_nxt = pidaw_pkg::ST_OUT;
      pidaw_pkg::ST_OUT:  if (out_ready) state_nxt = pidaw_pkg::ST_IDLE;
      default: state_nxt = pidaw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pidaw_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0; gain_i_r <= '0; gain_d_r <= '0;
      out_min_r <= 32'sh8000_0000; out_max_r <= 32'sh7fff_ffff; bias_r <= '0;
      discount_r <= 18'd65536; mode_r <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pidaw_pkg::REG_GAIN_P:   gain_p_r <= cfg_data;
        pidaw_pkg::REG_GAIN_I:   gain_i_r <= cfg_data;
        pidaw_pkg::REG_GAIN_D:   gain_d_r <= cfg_data;
        pidaw_pkg::REG_OUT_MIN:  out_min_r <= cfg_data;
        pidaw_pkg::REG_OUT_MAX:  out_max_r <= cfg_data;
        pidaw_pkg::REG_BIAS:     bias_r <= cfg_data;
        pidaw_pkg::REG_DISCOUNT: discount_r <= cfg_data[17:0];
        pidaw_pkg::REG_MODE:     mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // datapath
  logic signed [33:0] diff;
  assign diff = 34'(err_r) - 34'(prev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0; held_r <= '0; prev_r <= '0; cnt_r <= '0;
    end else begin
      case (state_r)
        pidaw_pkg::ST_IDLE: if (in_valid) begin
          err_r  <= 33'(in_goal) - 33'(in_measured);
          step_r <= in_step_time;
          if (in_cmd == pidaw_pkg::CMD_RESET) begin
            integ_r <= '0; held_r <= '0;
            prev_r <= 33'(in_goal) - 33'(in_measured);
          end else if (in_cmd == pidaw_pkg::CMD_CLEAR) integ_r <= '0;
        end
        pidaw_pkg::ST_P: if (mph_r) p_r <= mres;
        pidaw_pkg::ST_DISC: if (mph_r) disc_r <= mres;
        pidaw_pkg::ST_EI: if (mph_r) ei_r <= mres;
        pidaw_pkg::ST_INC: if (mph_r) begin
          inc_r <= mres;
          dneg_r <= diff[33];
          // dividend is the error difference magnitude scaled by 2^24
          dvd_r <= 66'(diff[33] ? 34'(-diff) : diff) << pidaw_pkg::STEP_FRAC;
          rem_r <= '0;
          cnt_r <= '0;
        end
        pidaw_pkg::ST_DIV: begin
          // clamped integral and bias plus p settle while the divider runs
          icl_r <= integ_cl;
          pb_r <= 64'(bias_r) + p_r;
          if (cnt_r != 7'(DW)) begin
            cnt_r <= cnt_r + 7'd1;
            if (!trial[DW]) begin
              rem_r <= trial[DW-1:0];
              dvd_r <= {dvd_r[DW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DW-2:0], dvd_r[DW-1]};
              dvd_r <= {dvd_r[DW-2:0], 1'b0};
            end
          end else begin
            q_r <= dneg_r ? -dvd_r[63:0] : dvd_r[63:0];
          end
        end
        pidaw_pkg::ST_D: if (mph_r) d_r <= mres;
        pidaw_pkg::ST_SUM: begin
          integ_r <= hold_int ? disc_sat[31:0] : icl_r[31:0];
          held_r <= out_cl[31:0];
          prev_r <= err_r;
        end
        pidaw_pkg::ST_FIN: held_r <= pfin[31:0];
        default: ;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive)) else $error("result lost");
  a_drive_lim: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(state_r) == pidaw_pkg::ST_SUM && out_min_r <= out_max_r
    |-> out_drive <= out_max_r && out_drive >= out_min_r) else $error("drive out of limits");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pidaw_pkg::ST_D |-> cnt_r == 7'(DW)) else $error("divider incomplete");
endmodule
